// File: src/dssg_pkg.sv
// Shared types, constants and helpers for the two-axis stepper sequencer.
// No dependencies; used by dssg_div, dssg_ctrl, dssg_dp and the top level.
`default_nettype none
package dssg_pkg;

  localparam int CNT_W       = 21;                // step counter width
  localparam int MOVE_W      = 21;                // move field width
  localparam int CAL_W       = 11;                // calibration register width
  localparam int SCALE_SHIFT = 9;                 // sensor scale of 512 as a shift
  localparam int DIV_W       = MOVE_W + SCALE_SHIFT;
  localparam int REM_W       = CNT_W + 1;
  localparam int ITER_W      = $clog2(DIV_W + 1);
  localparam int OP_W        = 3;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CNT_W-1:0]        CNT_MAX   = {CNT_W{1'b1}};
  localparam logic signed [CAL_W-1:0] CAL_RESET = 11'sd341;
  localparam logic signed [CAL_W-1:0] CAL_HI    = 11'sd1022;
  localparam logic signed [CAL_W-1:0] CAL_LO    = -11'sd1022;
  localparam logic [2:0]              PHASE_RST = 3'd1;

  localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
  localparam logic [OP_W-1:0] OP_LOAD   = 3'd1;
  localparam logic [OP_W-1:0] OP_SYNC   = 3'd2;
  localparam logic [OP_W-1:0] OP_SCALED = 3'd3;
  localparam logic [OP_W-1:0] OP_STOP   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_CAL_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAL_B = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE_A,
    ST_SCALE_B,
    ST_SYNC,
    ST_RATIO,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic latch_in;    // capture op, motor B move and motor A sign
    logic load_raw;    // counts straight from the input move fields
    logic div_init_a;  // scaled divide for motor A
    logic div_init_b;  // scaled divide for motor B
    logic div_init_r;  // pacing ratio divide
    logic div_step;
    logic set_a;       // take quotient as motor A count
    logic set_b;
    logic set_sync;    // take quotient as pacing ratio
    logic commit;      // apply item and load the output register
  } cmd_t;

  typedef struct packed {
    logic running;
    logic need_ratio;
    logic div_done;
    logic out_free;
  } status_t;

  // Coil drive for one four-coil motor; odd phases are the ones used.
  function automatic logic [3:0] coil_lut(input logic [2:0] ph);
    logic [3:0] c;
    case (ph)
      3'd0:    c = 4'h1;
      3'd1:    c = 4'h3;
      3'd2:    c = 4'h2;
      3'd3:    c = 4'h6;
      3'd4:    c = 4'h4;
      3'd5:    c = 4'hC;
      3'd6:    c = 4'h8;
      3'd7:    c = 4'h9;
      default: c = 4'h0;
    endcase
    return c;
  endfunction

  function automatic logic [MOVE_W-1:0] move_mag(input logic [MOVE_W-1:0] v);
    return v[MOVE_W-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic [CAL_W-1:0] cal_mag(input logic [CAL_W-1:0] v);
    return v[CAL_W-1] ? (~v + 1'b1) : v;
  endfunction

  function automatic logic cal_ok(input logic signed [CAL_W-1:0] v);
    return (v != '0) && (v <= CAL_HI) && (v >= CAL_LO);
  endfunction

endpackage
`default_nettype wire

// File: src/dssg_div.sv
// Restoring serial divider, one quotient bit per cycle while step is high.
// Depends on dssg_pkg for widths.
`default_nettype none
module dssg_div (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  input  wire logic                        step,
  input  wire logic [dssg_pkg::DIV_W-1:0]  dividend,
  input  wire logic [dssg_pkg::CNT_W-1:0]  divisor,
  input  wire logic [dssg_pkg::ITER_W-1:0] iters,
  output logic                             done,
  output logic [dssg_pkg::DIV_W-1:0]       quot
);

  logic [dssg_pkg::REM_W-1:0]  rem_r, rem_nxt;
  logic [dssg_pkg::DIV_W-1:0]  quo_r, quo_nxt;
  logic [dssg_pkg::CNT_W-1:0]  dvs_r, dvs_nxt;
  logic [dssg_pkg::ITER_W-1:0] cnt_r, cnt_nxt;
  logic [dssg_pkg::REM_W-1:0]  rem_sh;
  logic [dssg_pkg::REM_W-1:0]  rem_dif;
  logic                        ge;

  always_comb begin
    rem_sh  = {rem_r[dssg_pkg::REM_W-2:0], quo_r[dssg_pkg::DIV_W-1]};
    rem_dif = rem_sh - {1'b0, dvs_r};
    ge      = rem_sh >= {1'b0, dvs_r};
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    dvs_nxt = dvs_r;
    cnt_nxt = cnt_r;
    if (start) begin
      rem_nxt = '0;
      quo_nxt = dividend;
      dvs_nxt = divisor;
      cnt_nxt = iters;
    end else if (step && (cnt_r != '0)) begin
      rem_nxt = ge ? rem_dif : rem_sh;
      quo_nxt = {quo_r[dssg_pkg::DIV_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign done = (cnt_r == '0);
  assign quot = quo_r;

endmodule
`default_nettype wire

// File: src/dssg_ctrl.sv
// Sequencing controller: accepts items and walks the datapath through
// scaling, ratio division and commit. Depends on dssg_pkg.
`default_nettype none
module dssg_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  input  wire logic [dssg_pkg::OP_W-1:0] in_op,
  output logic                           in_stall,
  input  wire dssg_pkg::status_t         status,
  output dssg_pkg::cmd_t                 cmd
);

  dssg_pkg::state_t state_r, state_nxt;
  logic             is_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dssg_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    is_load   = (in_op == dssg_pkg::OP_LOAD) || (in_op == dssg_pkg::OP_SYNC) ||
                (in_op == dssg_pkg::OP_SCALED);
    cmd       = '0;
    state_nxt = state_r;
    in_stall  = (state_r != dssg_pkg::ST_IDLE);
    case (state_r)
      dssg_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          if (is_load && !status.running) begin
            if (in_op == dssg_pkg::OP_SCALED) begin
              cmd.div_init_a = 1'b1;
              state_nxt      = dssg_pkg::ST_SCALE_A;
            end else begin
              cmd.load_raw = 1'b1;
              state_nxt    = dssg_pkg::ST_SYNC;
            end
          end else begin
            // tick, stop, rejected load, unused codes
            state_nxt = dssg_pkg::ST_FINISH;
          end
        end
      end
      dssg_pkg::ST_SCALE_A: begin
        if (!status.div_done) begin
          cmd.div_step = 1'b1;
        end else begin
          cmd.set_a      = 1'b1;
          cmd.div_init_b = 1'b1;
          state_nxt      = dssg_pkg::ST_SCALE_B;
        end
      end
      dssg_pkg::ST_SCALE_B: begin
        if (!status.div_done) begin
          cmd.div_step = 1'b1;
        end else begin
          cmd.set_b = 1'b1;
          state_nxt = dssg_pkg::ST_SYNC;
        end
      end
      dssg_pkg::ST_SYNC: begin
        if (status.need_ratio) begin
          cmd.div_init_r = 1'b1;
          state_nxt      = dssg_pkg::ST_RATIO;
        end else begin
          state_nxt = dssg_pkg::ST_FINISH;
        end
      end
      dssg_pkg::ST_RATIO: begin
        if (!status.div_done) begin
          cmd.div_step = 1'b1;
        end else begin
          cmd.set_sync = 1'b1;
          state_nxt    = dssg_pkg::ST_FINISH;
        end
      end
      dssg_pkg::ST_FINISH: begin
        if (status.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = dssg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = dssg_pkg::ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// File: src/dssg_dp.sv
// Datapath: motor state, calibration registers, divider operand muxing,
// tick stepping and the output register. Depends on dssg_pkg and dssg_div.
`default_nettype none
module dssg_dp (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire dssg_pkg::cmd_t                        cmd,
  output dssg_pkg::status_t                          status,
  input  wire logic [dssg_pkg::OP_W-1:0]             in_op,
  input  wire logic signed [dssg_pkg::MOVE_W-1:0]    in_move_a,
  input  wire logic signed [dssg_pkg::MOVE_W-1:0]    in_move_b,
  input  wire logic                                  cfg_valid,
  input  wire logic [dssg_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic signed [dssg_pkg::CAL_W-1:0]     cfg_data,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic [3:0]                                 out_coils_a,
  output logic [3:0]                                 out_coils_b,
  output logic                                       out_busy_res,
  output logic                                       out_finished,
  output logic                                       out_rejected
);

  localparam int CW = dssg_pkg::CNT_W;
  localparam int PAD = dssg_pkg::DIV_W - dssg_pkg::CNT_W;

  logic signed [dssg_pkg::CAL_W-1:0] cal_a_r, cal_b_r;
  logic [dssg_pkg::OP_W-1:0]         op_r;
  logic [dssg_pkg::MOVE_W-1:0]       mb_r;
  logic                              ma_neg_r;

  logic [CW-1:0] left_a_r, left_a_nxt, left_b_r, left_b_nxt;
  logic          rev_a_r, rev_a_nxt, rev_b_r, rev_b_nxt;
  logic [2:0]    ph_a_r, ph_a_nxt, ph_b_r, ph_b_nxt;
  logic          slv_a_r, slv_a_nxt, slv_b_r, slv_b_nxt;
  logic [CW-1:0] pm_a_r, pm_a_nxt, pm_b_r, pm_b_nxt;
  logic [CW-1:0] rat_a_r, rat_a_nxt, rat_b_r, rat_b_nxt;
  logic          run_r, run_nxt;
  logic [1:0]    en_r, en_nxt;

  logic          ov_r, ov_nxt;
  logic [3:0]    oc_a_r, oc_a_nxt, oc_b_r, oc_b_nxt;
  logic          obusy_r, obusy_nxt, ofin_r, ofin_nxt, orej_r, orej_nxt;

  logic                              div_start;
  logic [dssg_pkg::DIV_W-1:0]        div_dvd;
  logic [CW-1:0]                     div_dvs;
  logic [dssg_pkg::ITER_W-1:0]       div_it;
  logic                              div_done;
  logic [dssg_pkg::DIV_W-1:0]        div_q;

  logic [CW-1:0] q_sat;
  logic          q_zero;
  logic          a_gt_b;
  logic          is_load;
  logic          a_go, b_go, a_hit, b_hit;
  logic [CW-1:0] left_a_t;
  logic          fin;

  dssg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .step     (cmd.div_step),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .iters    (div_it),
    .done     (div_done),
    .quot     (div_q)
  );

  // divider operand select
  always_comb begin
    a_gt_b    = left_a_r > left_b_r;
    div_start = cmd.div_init_a | cmd.div_init_b | cmd.div_init_r;
    div_dvd   = {dssg_pkg::move_mag(in_move_a), dssg_pkg::SCALE_SHIFT'(0)};
    div_dvs   = CW'(dssg_pkg::cal_mag(cal_a_r));
    div_it    = dssg_pkg::ITER_W'(dssg_pkg::DIV_W);
    if (cmd.div_init_b) begin
      div_dvd = {dssg_pkg::move_mag(mb_r), dssg_pkg::SCALE_SHIFT'(0)};
      div_dvs = CW'(dssg_pkg::cal_mag(cal_b_r));
    end else if (cmd.div_init_r) begin
      // larger count over smaller, top aligned so CNT_W steps suffice
      div_dvd = a_gt_b ? {left_a_r, PAD'(0)} : {left_b_r, PAD'(0)};
      div_dvs = a_gt_b ? left_b_r : left_a_r;
      div_it  = dssg_pkg::ITER_W'(CW);
    end
  end

  assign q_zero = (div_q == '0);
  assign q_sat  = (div_q[dssg_pkg::DIV_W-1:CW] != '0) ? dssg_pkg::CNT_MAX : div_q[CW-1:0];

  always_comb begin
    is_load = (op_r == dssg_pkg::OP_LOAD) || (op_r == dssg_pkg::OP_SYNC) ||
              (op_r == dssg_pkg::OP_SCALED);

    // one tick: motor A first, motor B then sees A's updated count
    a_hit    = (pm_b_r == left_b_r);
    a_go     = (left_a_r != '0) && (!slv_a_r || a_hit);
    left_a_t = a_go ? left_a_r - 1'b1 : left_a_r;
    b_hit    = (pm_a_r == left_a_t);
    b_go     = (left_b_r != '0) && (!slv_b_r || b_hit);
    fin      = (left_a_t == '0) && (left_b_r - CW'(b_go) == '0);

    left_a_nxt = left_a_r;
    left_b_nxt = left_b_r;
    rev_a_nxt  = rev_a_r;
    rev_b_nxt  = rev_b_r;
    ph_a_nxt   = ph_a_r;
    ph_b_nxt   = ph_b_r;
    slv_a_nxt  = slv_a_r;
    slv_b_nxt  = slv_b_r;
    pm_a_nxt   = pm_a_r;
    pm_b_nxt   = pm_b_r;
    rat_a_nxt  = rat_a_r;
    rat_b_nxt  = rat_b_r;
    run_nxt    = run_r;
    en_nxt     = en_r;
    ov_nxt     = ov_r & out_stall;
    oc_a_nxt   = oc_a_r;
    oc_b_nxt   = oc_b_r;
    obusy_nxt  = obusy_r;
    ofin_nxt   = ofin_r;
    orej_nxt   = orej_r;

    if (cmd.load_raw) begin
      left_a_nxt = dssg_pkg::move_mag(in_move_a);
      left_b_nxt = dssg_pkg::move_mag(in_move_b);
      rev_a_nxt  = in_move_a[dssg_pkg::MOVE_W-1];
      rev_b_nxt  = in_move_b[dssg_pkg::MOVE_W-1];
    end
    if (cmd.load_raw || cmd.div_init_a) begin
      slv_a_nxt = 1'b0;
      slv_b_nxt = 1'b0;
    end
    if (cmd.set_a) begin
      left_a_nxt = q_sat;
      rev_a_nxt  = (ma_neg_r ^ cal_a_r[dssg_pkg::CAL_W-1]) && !q_zero;
    end
    if (cmd.set_b) begin
      left_b_nxt = q_sat;
      rev_b_nxt  = (mb_r[dssg_pkg::MOVE_W-1] ^ cal_b_r[dssg_pkg::CAL_W-1]) && !q_zero;
    end
    if (cmd.set_sync) begin
      if (a_gt_b) begin
        slv_b_nxt = 1'b1;
        rat_a_nxt = div_q[CW-1:0];
        pm_a_nxt  = left_a_r - div_q[CW-1:0];
      end else begin
        slv_a_nxt = 1'b1;
        rat_b_nxt = div_q[CW-1:0];
        pm_b_nxt  = left_b_r - div_q[CW-1:0];
      end
    end

    if (cmd.commit) begin
      ofin_nxt = 1'b0;
      orej_nxt = 1'b0;
      if (is_load) begin
        if (run_r) begin
          orej_nxt = 1'b1;
        end else begin
          run_nxt = 1'b1;
        end
      end else if (op_r == dssg_pkg::OP_STOP) begin
        run_nxt = 1'b0;
        en_nxt  = 2'b00;
      end else if ((op_r == dssg_pkg::OP_TICK) && run_r) begin
        left_a_nxt = left_a_t;
        if (a_go) begin
          ph_a_nxt = rev_a_r ? ph_a_r + 3'd6 : ph_a_r + 3'd2;
        end
        if ((left_a_r != '0) && slv_a_r && a_hit) begin
          pm_b_nxt = (pm_b_r < rat_b_r) ? '0 : pm_b_r - rat_b_r;
        end
        if (b_go) begin
          left_b_nxt = left_b_r - 1'b1;
          ph_b_nxt   = rev_b_r ? ph_b_r + 3'd6 : ph_b_r + 3'd2;
        end
        if ((left_b_r != '0) && slv_b_r && b_hit) begin
          pm_a_nxt = (pm_a_r < rat_a_r) ? '0 : pm_a_r - rat_a_r;
        end
        en_nxt = en_r | {b_go, a_go};
        if (fin) begin
          en_nxt   = 2'b00;
          run_nxt  = 1'b0;
          ofin_nxt = 1'b1;
        end
      end
      ov_nxt    = 1'b1;
      oc_a_nxt  = en_nxt[0] ? dssg_pkg::coil_lut(ph_a_nxt) : 4'h0;
      oc_b_nxt  = en_nxt[1] ? dssg_pkg::coil_lut(ph_b_nxt) : 4'h0;
      obusy_nxt = run_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_r     <= in_op;
      mb_r     <= in_move_b;
      ma_neg_r <= in_move_a[dssg_pkg::MOVE_W-1];
    end
    oc_a_r  <= oc_a_nxt;
    oc_b_r  <= oc_b_nxt;
    obusy_r <= obusy_nxt;
    ofin_r  <= ofin_nxt;
    orej_r  <= orej_nxt;
    if (!rst_n) begin
      cal_a_r  <= dssg_pkg::CAL_RESET;
      cal_b_r  <= dssg_pkg::CAL_RESET;
      left_a_r <= '0;
      left_b_r <= '0;
      rev_a_r  <= 1'b0;
      rev_b_r  <= 1'b0;
      ph_a_r   <= dssg_pkg::PHASE_RST;
      ph_b_r   <= dssg_pkg::PHASE_RST;
      slv_a_r  <= 1'b0;
      slv_b_r  <= 1'b0;
      pm_a_r   <= '0;
      pm_b_r   <= '0;
      rat_a_r  <= '0;
      rat_b_r  <= '0;
      run_r    <= 1'b0;
      en_r     <= 2'b00;
      ov_r     <= 1'b0;
    end else begin
      if (cfg_valid && (cfg_index == dssg_pkg::CFG_CAL_A) && dssg_pkg::cal_ok(cfg_data)) begin
        cal_a_r <= cfg_data;
      end
      if (cfg_valid && (cfg_index == dssg_pkg::CFG_CAL_B) && dssg_pkg::cal_ok(cfg_data)) begin
        cal_b_r <= cfg_data;
      end
      left_a_r <= left_a_nxt;
      left_b_r <= left_b_nxt;
      rev_a_r  <= rev_a_nxt;
      rev_b_r  <= rev_b_nxt;
      ph_a_r   <= ph_a_nxt;
      ph_b_r   <= ph_b_nxt;
      slv_a_r  <= slv_a_nxt;
      slv_b_r  <= slv_b_nxt;
      pm_a_r   <= pm_a_nxt;
      pm_b_r   <= pm_b_nxt;
      rat_a_r  <= rat_a_nxt;
      rat_b_r  <= rat_b_nxt;
      run_r    <= run_nxt;
      en_r     <= en_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_comb begin
    status.running    = run_r;
    status.need_ratio = (op_r != dssg_pkg::OP_LOAD) && (left_a_r != '0) &&
                        (left_b_r != '0) && (left_a_r != left_b_r);
    status.div_done   = div_done;
    status.out_free   = !ov_r || !out_stall;
  end

  assign out_valid    = ov_r;
  assign out_coils_a  = oc_a_r;
  assign out_coils_b  = oc_b_r;
  assign out_busy_res = obusy_r;
  assign out_finished = ofin_r;
  assign out_rejected = orej_r;

endmodule
`default_nettype wire

// File: src/dual_stepper_sync_step_generator.sv
// Two-axis stepper step sequencer, top level. One result per item, held in an
// output register. The next item is accepted only after the current one is
// committed. Scaled counts and the pacing ratio are set by the single shared
// serial divider, one bit per cycle.
// Reset (rst_n low, synchronous): idle, motors stopped, output invalid, calibration back to 341.
`default_nettype none
module dual_stepper_sync_step_generator (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [dssg_pkg::OP_W-1:0]           in_op,
  input  wire logic signed [dssg_pkg::MOVE_W-1:0]  in_move_a,
  input  wire logic signed [dssg_pkg::MOVE_W-1:0]  in_move_b,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [3:0]                               out_coils_a,
  output logic [3:0]                               out_coils_b,
  output logic                                     out_busy_res,
  output logic                                     out_finished,
  output logic                                     out_rejected,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [dssg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic signed [dssg_pkg::CAL_W-1:0]   cfg_data
);

  dssg_pkg::cmd_t    cmd;
  dssg_pkg::status_t status;

  // calibration transfers are always taken
  assign cfg_ready = 1'b1;

  dssg_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_op),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  dssg_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .status       (status),
    .in_op        (in_op),
    .in_move_a    (in_move_a),
    .in_move_b    (in_move_b),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_coils_a  (out_coils_a),
    .out_coils_b  (out_coils_b),
    .out_busy_res (out_busy_res),
    .out_finished (out_finished),
    .out_rejected (out_rejected)
  );

endmodule
`default_nettype wire

// File: dv/dual_stepper_sync_step_generator_test.sv
// Self-checking testbench for the two-axis stepper step sequencer: directed and random
// command streams are scored against an in-bench predictor of coil drive and move flags.
// Depends on dssg_pkg and dual_stepper_sync_step_generator.
`default_nettype none
module dual_stepper_sync_step_generator_test;

  localparam logic [dssg_pkg::OP_W-1:0]      OP_RSVD_5   = 3'd5;
  localparam logic [dssg_pkg::OP_W-1:0]      OP_RSVD_6   = 3'd6;
  localparam logic [dssg_pkg::OP_W-1:0]      OP_RSVD_7   = 3'd7;
  localparam logic [dssg_pkg::CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [dssg_pkg::CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;
  localparam int     IDLE_PCT       = 6;
  localparam int     WATCHDOG_LIMIT = 4000;
  localparam int     SETTLE_CYCLES  = 100;
  localparam int     RANDOM_ITEMS   = 670;
  localparam longint SENSOR_SCALE   = 512;
  // low nibble of the coil pattern per phase, phase 0 in bits 3:0
  localparam logic [31:0] COIL_SEQ  = 32'h98C46231;

  typedef struct packed {
    logic [dssg_pkg::OP_W-1:0]          op;
    logic signed [dssg_pkg::MOVE_W-1:0] move_a;
    logic signed [dssg_pkg::MOVE_W-1:0] move_b;
  } step_cmd_t;

  typedef struct packed {
    logic [3:0] coils_a;
    logic [3:0] coils_b;
    logic       busy;
    logic       finished;
    logic       rejected;
  } coil_state_t;

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               in_valid = 1'b0;
  logic                               in_stall;
  logic [dssg_pkg::OP_W-1:0]          in_op = dssg_pkg::OP_TICK;
  logic signed [dssg_pkg::MOVE_W-1:0] in_move_a = '0;
  logic signed [dssg_pkg::MOVE_W-1:0] in_move_b = '0;
  logic                               out_valid;
  logic                               out_stall = 1'b0;
  logic [3:0]                         out_coils_a;
  logic [3:0]                         out_coils_b;
  logic                               out_busy_res;
  logic                               out_finished;
  logic                               out_rejected;
  logic                               cfg_valid = 1'b0;
  logic                               cfg_ready;
  logic [dssg_pkg::CFG_IDX_W-1:0]     cfg_index = dssg_pkg::CFG_CAL_A;
  logic signed [dssg_pkg::CAL_W-1:0]  cfg_data = '0;

  // predictor state
  logic signed [dssg_pkg::CAL_W-1:0] cal_a, cal_b;
  logic [dssg_pkg::CNT_W-1:0]        cnt_a, cnt_b, mark_a, mark_b, pace_a, pace_b;
  logic                              rev_a, rev_b, follow_a, follow_b, moving;
  logic [2:0]                        ph_a, ph_b;
  logic [1:0]                        coil_on;

  coil_state_t expected_steps[$];
  coil_state_t want_step;
  int          errors = 0;
  int          items_sent = 0;
  int          idle_cycles = 0;
  logic        quiet = 1'b0;

  dual_stepper_sync_step_generator u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_move_a    (in_move_a),
    .in_move_b    (in_move_b),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_coils_a  (out_coils_a),
    .out_coils_b  (out_coils_b),
    .out_busy_res (out_busy_res),
    .out_finished (out_finished),
    .out_rejected (out_rejected),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [dssg_pkg::CNT_W-1:0] clamp_count(input longint v);
    longint mag;
    mag = (v < 0) ? -v : v;
    return (mag > longint'(dssg_pkg::CNT_MAX)) ? dssg_pkg::CNT_MAX : mag[dssg_pkg::CNT_W-1:0];
  endfunction

  function automatic coil_state_t sequencer_step(input step_cmd_t cmd);
    longint      qa, qb;
    logic        go;
    coil_state_t r;
    r = '0;
    if (cmd.op == dssg_pkg::OP_LOAD || cmd.op == dssg_pkg::OP_SYNC ||
        cmd.op == dssg_pkg::OP_SCALED) begin
      if (moving) begin
        r.rejected = 1'b1;
      end else begin
        qa = longint'($signed(cmd.move_a));
        qb = longint'($signed(cmd.move_b));
        if (cmd.op == dssg_pkg::OP_SCALED) begin
          // truncates toward zero, negative calibration flips direction
          qa = (qa * SENSOR_SCALE) / longint'(cal_a);
          qb = (qb * SENSOR_SCALE) / longint'(cal_b);
        end
        rev_a = qa < 0;
        rev_b = qb < 0;
        cnt_a = clamp_count(qa);
        cnt_b = clamp_count(qb);
        follow_a = 1'b0;
        follow_b = 1'b0;
        if (cmd.op != dssg_pkg::OP_LOAD && cnt_a != 0 && cnt_b != 0) begin
          if (cnt_a > cnt_b) begin
            follow_b = 1'b1;
            pace_a = cnt_a / cnt_b;
            mark_a = cnt_a - pace_a;
          end else if (cnt_a < cnt_b) begin
            follow_a = 1'b1;
            pace_b = cnt_b / cnt_a;
            mark_b = cnt_b - pace_b;
          end
        end
        moving = 1'b1;
      end
    end else if (cmd.op == dssg_pkg::OP_STOP) begin
      moving = 1'b0;
      coil_on = 2'b00;
    end else if (cmd.op == dssg_pkg::OP_TICK && moving) begin
      if (cnt_a != 0) begin
        go = 1'b1;
        if (follow_a) begin
          if (mark_b == cnt_b) mark_b = (mark_b < pace_b) ? '0 : mark_b - pace_b;
          else go = 1'b0;
        end
        if (go) begin
          cnt_a = cnt_a - 1'b1;
          ph_a = rev_a ? ph_a + 3'd6 : ph_a + 3'd2;
          coil_on[0] = 1'b1;
        end
      end
      // B sees A's count after A's step of this tick
      if (cnt_b != 0) begin
        go = 1'b1;
        if (follow_b) begin
          if (mark_a == cnt_a) mark_a = (mark_a < pace_a) ? '0 : mark_a - pace_a;
          else go = 1'b0;
        end
        if (go) begin
          cnt_b = cnt_b - 1'b1;
          ph_b = rev_b ? ph_b + 3'd6 : ph_b + 3'd2;
          coil_on[1] = 1'b1;
        end
      end
      if (cnt_a == 0 && cnt_b == 0) begin
        coil_on = 2'b00;
        moving = 1'b0;
        r.finished = 1'b1;
      end
    end
    r.coils_a = coil_on[0] ? COIL_SEQ[ph_a*4 +: 4] : 4'h0;
    r.coils_b = coil_on[1] ? COIL_SEQ[ph_b*4 +: 4] : 4'h0;
    r.busy = moving;
    return r;
  endfunction

  function automatic logic signed [dssg_pkg::MOVE_W-1:0] any_move();
    logic [31:0] r;
    r = $urandom();
    return r[dssg_pkg::MOVE_W-1:0];
  endfunction

  function automatic logic signed [dssg_pkg::MOVE_W-1:0] rand_move();
    logic [dssg_pkg::MOVE_W-1:0] m;
    case ($urandom_range(0, 9))
      0:       m = any_move();
      1:       m = '0;
      2:       m = dssg_pkg::MOVE_W'($urandom_range(0, 60));
      default: m = dssg_pkg::MOVE_W'($urandom_range(0, 12));
    endcase
    if ($urandom_range(1)) m = -m;
    return m;
  endfunction

  task automatic send_cmd(input logic [dssg_pkg::OP_W-1:0] op,
                          input logic signed [dssg_pkg::MOVE_W-1:0] a,
                          input logic signed [dssg_pkg::MOVE_W-1:0] b);
    step_cmd_t   cmd;
    coil_state_t res;
    @(negedge clk);
    while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_op     <= op;
    in_move_a <= a;
    in_move_b <= b;
    cmd.op = op;
    cmd.move_a = a;
    cmd.move_b = b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    res = sequencer_step(cmd);
    expected_steps.push_back(res);
    if (!res.rejected && op <= dssg_pkg::OP_STOP) items_sent++;
  endtask

  // leave the input idle and let every outstanding result come back
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_steps.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cal(input logic [dssg_pkg::CFG_IDX_W-1:0] idx,
                           input logic signed [dssg_pkg::CAL_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (data != 0 && data <= 1022 && data >= -1022) begin
      if (idx == dssg_pkg::CFG_CAL_A) cal_a = data;
      else if (idx == dssg_pkg::CFG_CAL_B) cal_b = data;
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic finish_move(input int cap);
    int n;
    n = 0;
    while (moving && n < cap) begin
      send_cmd(dssg_pkg::OP_TICK, any_move(), any_move());
      n++;
    end
    if (moving) send_cmd(dssg_pkg::OP_STOP, any_move(), any_move());
  endtask

  task automatic test_idle_ops();
    send_cmd(dssg_pkg::OP_TICK, 21'sd5, -21'sd5);
    send_cmd(dssg_pkg::OP_STOP, '0, '0);
    send_cmd(OP_RSVD_5, 21'sd1, 21'sd1);
    send_cmd(OP_RSVD_6, -21'sd1, 21'sd0);
    send_cmd(OP_RSVD_7, 21'sd0, -21'sd1);
  endtask

  task automatic test_basic_moves();
    send_cmd(dssg_pkg::OP_LOAD, '0, '0);            // zero move ends on the next tick
    finish_move(2);
    send_cmd(dssg_pkg::OP_LOAD, 21'sd3, -21'sd2);
    send_cmd(dssg_pkg::OP_SYNC, 21'sd1, 21'sd1);    // rejected while busy
    finish_move(10);
  endtask

  task automatic test_synced_moves();
    send_cmd(dssg_pkg::OP_SYNC, 21'sd5, -21'sd2);   // B follows A
    finish_move(12);
    send_cmd(dssg_pkg::OP_SYNC, -21'sd1, 21'sd4);   // A follows B
    finish_move(12);
    send_cmd(dssg_pkg::OP_SYNC, 21'sd3, -21'sd3);   // equal counts, nobody follows
    send_cmd(dssg_pkg::OP_TICK, '0, '0);
    send_cmd(dssg_pkg::OP_STOP, '0, '0);
    send_cmd(dssg_pkg::OP_SYNC, '0, 21'sd2);        // one count zero
    finish_move(4);
  endtask

  task automatic test_extremes();
    send_cmd(dssg_pkg::OP_SYNC, 21'sd1048575, -21'sd1048576);
    send_cmd(dssg_pkg::OP_TICK, '0, '0);
    send_cmd(dssg_pkg::OP_STOP, '0, '0);
    send_cmd(dssg_pkg::OP_SCALED, -21'sd1048576, 21'sd1048575);
    finish_move(2);
  endtask

  task automatic test_calibration();
    write_cal(dssg_pkg::CFG_CAL_A, 11'sd1022);
    write_cal(dssg_pkg::CFG_CAL_B, -11'sd1022);
    send_cmd(dssg_pkg::OP_SCALED, 21'sd1, -21'sd1);  // quotients of zero
    finish_move(3);
    send_cmd(dssg_pkg::OP_SCALED, -21'sd7, 21'sd9);
    finish_move(20);
    drain();
    write_cal(dssg_pkg::CFG_CAL_A, -11'sd1);
    write_cal(dssg_pkg::CFG_CAL_B, 11'sd1);
    send_cmd(dssg_pkg::OP_SCALED, 21'sd1, -21'sd1);
    finish_move(3);
    send_cmd(dssg_pkg::OP_SCALED, 21'sd1048575, -21'sd1048576);  // saturates
    finish_move(2);
    drain();
    // none of these may take effect
    write_cal(dssg_pkg::CFG_CAL_A, 11'sd0);
    write_cal(dssg_pkg::CFG_CAL_B, 11'sd1023);
    write_cal(dssg_pkg::CFG_CAL_A, -11'sd1023);
    write_cal(dssg_pkg::CFG_CAL_B, -11'sd1024);
    write_cal(CFG_SPARE_2, 11'sd5);
    write_cal(CFG_SPARE_3, 11'sd7);
    send_cmd(dssg_pkg::OP_SCALED, 21'sd2, 21'sd3);
    finish_move(4);
    drain();
    write_cal(dssg_pkg::CFG_CAL_A, -11'sd1022);
    write_cal(dssg_pkg::CFG_CAL_B, 11'sd1022);
    send_cmd(dssg_pkg::OP_SCALED, 21'sd30, -21'sd11);
    finish_move(40);
    drain();
    write_cal(dssg_pkg::CFG_CAL_A, dssg_pkg::CAL_RESET);
    write_cal(dssg_pkg::CFG_CAL_B, dssg_pkg::CAL_RESET);
  endtask

  function automatic logic [dssg_pkg::OP_W-1:0] OP_OP_PICK();
    case ($urandom_range(0, 2))
      0:       return dssg_pkg::OP_LOAD;
      1:       return dssg_pkg::OP_SYNC;
      default: return dssg_pkg::OP_SCALED;
    endcase
  endfunction

  task automatic test_random();
    int   start;
    int   next_cal;
    logic paused;
    logic [31:0] r;
    start = items_sent;
    next_cal = 250;
    paused = 1'b0;
    while (items_sent - start < RANDOM_ITEMS) begin
      quiet = (items_sent - start >= 300) && (items_sent - start < 450);
      if (!paused && items_sent - start >= 200) begin
        drain();
        paused = 1'b1;
      end
      if (items_sent - start >= next_cal) begin
        next_cal += 250;
        drain();
        r = $urandom();
        write_cal(r[12:11], r[dssg_pkg::CAL_W-1:0]);
        write_cal($urandom_range(0, 1) ? dssg_pkg::CFG_CAL_A : dssg_pkg::CFG_CAL_B,
                  dssg_pkg::CAL_W'($signed($urandom_range(0, 400)) - 200));
      end
      if ($urandom_range(0, 9) < 2) begin
        r = $urandom();
        send_cmd(r[dssg_pkg::OP_W-1:0], any_move(), any_move());
        if (moving && $urandom_range(1)) finish_move($urandom_range(0, 3));
      end else begin
        send_cmd(OP_OP_PICK(), rand_move(), rand_move());
        if ($urandom_range(0, 4) == 0) begin
          send_cmd(dssg_pkg::OP_TICK, any_move(), any_move());
          send_cmd(OP_OP_PICK(), rand_move(), rand_move());
        end
        finish_move(($urandom_range(0, 4) == 0) ? $urandom_range(0, 6) : 80);
      end
    end
    quiet = 1'b0;
  endtask

  task automatic check_field(input string name, input logic [3:0] want, input logic [3:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_steps.size() == 0) begin
        $error("result transfer with no expected result pending");
        errors++;
      end else begin
        want_step = expected_steps.pop_front();
        check_field("coils_a", want_step.coils_a, out_coils_a);
        check_field("coils_b", want_step.coils_b, out_coils_b);
        check_field("busy_res", {3'b0, want_step.busy}, {3'b0, out_busy_res});
        check_field("finished", {3'b0, want_step.finished}, {3'b0, out_finished});
        check_field("rejected", {3'b0, want_step.rejected}, {3'b0, out_rejected});
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= rst_n && !quiet && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // any transfer on any channel resets the count
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    cal_a = dssg_pkg::CAL_RESET;
    cal_b = dssg_pkg::CAL_RESET;
    cnt_a = '0;
    cnt_b = '0;
    mark_a = '0;
    mark_b = '0;
    pace_a = '0;
    pace_b = '0;
    rev_a = 1'b0;
    rev_b = 1'b0;
    follow_a = 1'b0;
    follow_b = 1'b0;
    moving = 1'b0;
    ph_a = dssg_pkg::PHASE_RST;
    ph_b = dssg_pkg::PHASE_RST;
    coil_on = 2'b00;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_idle_ops();
    test_basic_moves();
    test_synced_moves();
    test_extremes();
    drain();
    test_calibration();
    test_random();
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && expected_steps.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: filelist.f
src/dssg_pkg.sv
src/dssg_div.sv
src/dssg_ctrl.sv
src/dssg_dp.sv
src/dual_stepper_sync_step_generator.sv
dv/dual_stepper_sync_step_generator_test.sv
